@@ hdl/hsv_pkg.sv @@
// Shared types and constants of the HSV to RGB converter.
// Used by hsv_cdiv and hsv_to_rgb_scaled_top; depends on nothing else.
package hsv_pkg;

   localparam int unsigned HUE_BITS       = 16;
   localparam int unsigned SAT_BITS       = 9;
   localparam int unsigned VALUE_BITS     = 9;
   localparam int unsigned CHROMA_BITS    = SAT_BITS + VALUE_BITS;
   localparam int unsigned BRIGHT_BITS    = 8;
   localparam int unsigned LEVEL_OUT_BITS = 8;
   localparam int unsigned SECTOR_COUNT   = 6;
   localparam int unsigned SECTOR_BITS    = 3;
   localparam int unsigned CHANNEL_COUNT  = 3;

   localparam logic [BRIGHT_BITS-1:0] BRIGHTNESS_RESET = 8'd50;

   // What a channel holds above m: c, x, c - x or nothing.
   typedef enum logic [1:0] {
      TERM_CHROMA,
      TERM_RISE,
      TERM_FALL,
      TERM_ZERO
   } term_type;

   typedef struct packed {
      term_type red;
      term_type green;
      term_type blue;
   } terms_type;

   // Pipeline step control handed to a stage module.
   typedef struct packed {
      logic advance;
      logic valid;
   } pipe_ctl_type;

   // Hexcone sector pattern; codes beyond the sixth sector never occur.
   function automatic terms_type sector_terms(logic [SECTOR_BITS-1:0] sector);
      terms_type terms;
      case (sector)
         3'd0: terms = '{TERM_CHROMA, TERM_RISE,   TERM_ZERO};
         3'd1: terms = '{TERM_FALL,   TERM_CHROMA, TERM_ZERO};
         3'd2: terms = '{TERM_ZERO,   TERM_CHROMA, TERM_RISE};
         3'd3: terms = '{TERM_ZERO,   TERM_FALL,   TERM_CHROMA};
         3'd4: terms = '{TERM_RISE,   TERM_ZERO,   TERM_CHROMA};
         default: terms = '{TERM_CHROMA, TERM_ZERO, TERM_FALL};
      endcase
      return terms;
   endfunction

endpackage

@@ hdl/hsv_to_rgb_scaled_top.sv @@
// Top level of the HSV to RGB converter for LED pixel levels.
// Depends on hsv_pkg and instantiates hsv_cdiv (hue wrap and level quantizers).
//
// Converts one hue / saturation / value item per clock into red, green and
// blue levels. Hue is signed, in 1/2^HUE_FRAC_BITS degree units, wrapped
// into [0, 360) degrees; saturation and value are Q8 (256 = 1.0, larger
// codes are used as given and the channels then clamp). The hexcone rule
// gives each channel as m plus c, x, c - x or nothing; the channel is
// clamped to [0, 1], truncated to LEVEL_BITS fraction bits, multiplied by
// the brightness register and truncated to an 8-bit level. Throughput is
// one item per clock while req_ready is high. From acceptance to rsp_valid
// an item passes the input register, the three-stage hue wrap divider,
// sector decode, multiply, clamp, the three-stage quantizing divider
// per channel and the output register. A
// two-entry output buffer (output register plus skid register) lets the
// pipeline keep moving for one more item while a result waits; req_ready
// drops only when both entries are full. The brightness register is
// written through csr_write_enable / csr_write_data (reset value 50) and
// must only be written while no item is in flight.
module hsv_to_rgb_scaled_top
   import hsv_pkg::*;
#(
   parameter int unsigned HUE_FRAC_BITS = 4,
   parameter int unsigned LEVEL_BITS    = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [BRIGHT_BITS-1:0]      csr_write_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [HUE_BITS-1:0]  req_hue,
   input  logic [SAT_BITS-1:0]         req_saturation,
   input  logic [VALUE_BITS-1:0]       req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [LEVEL_OUT_BITS-1:0]   rsp_red,
   output logic [LEVEL_OUT_BITS-1:0]   rsp_green,
   output logic [LEVEL_OUT_BITS-1:0]   rsp_blue
);

   // Hue geometry.
   localparam int unsigned SECTOR     = 60 << HUE_FRAC_BITS;
   localparam int unsigned CIRCLE     = SECTOR_COUNT * SECTOR;
   localparam int unsigned SEC_BITS   = $clog2(SECTOR + 1);
   localparam int unsigned FRAC_BITS  = $clog2(SECTOR);
   localparam int unsigned WRAP_BITS  = $clog2(CIRCLE);
   localparam int unsigned HUE_SPAN   = 1 << HUE_BITS;
   localparam int unsigned HUE_OFFSET = (CIRCLE - ((HUE_SPAN / 2) % CIRCLE)) % CIRCLE;
   localparam int unsigned HNUM_BITS  = $clog2(HUE_SPAN + CIRCLE);
   localparam int unsigned HQUO_BITS  = $clog2((HUE_SPAN - 1 + CIRCLE) / CIRCLE + 1);
   // Channel numerators over 65536 * SECTOR.
   localparam int unsigned BASE_BITS  = VALUE_BITS + 8 + SEC_BITS;
   localparam int unsigned PROD_BITS  = CHROMA_BITS + SEC_BITS;
   localparam int unsigned NUM_BITS   = PROD_BITS + 1;
   localparam longint unsigned FULL_NUM = 64'd65536 * SECTOR;
   localparam int unsigned SHIFT      = 16 - LEVEL_BITS;
   localparam int unsigned QNUM_BITS  = LEVEL_BITS + FRAC_BITS;
   localparam int unsigned SCALE_BITS = LEVEL_BITS + 1 + BRIGHT_BITS;

   typedef logic [CHANNEL_COUNT-1:0][LEVEL_OUT_BITS-1:0] levels_type;

   function automatic logic [SEC_BITS-1:0] pick_units(term_type term,
                                                      logic [SEC_BITS-1:0] frac,
                                                      logic [SEC_BITS-1:0] rest);
      logic [SEC_BITS-1:0] units;
      case (term)
         TERM_CHROMA: units = '0;
         TERM_RISE:   units = rest;
         TERM_FALL:   units = frac;
         default:     units = SEC_BITS'(SECTOR);
      endcase
      return units;
   endfunction

   function automatic logic [LEVEL_OUT_BITS-1:0] scale_level(logic [LEVEL_BITS-1:0] quot,
                                                             logic low, logic high,
                                                             logic [BRIGHT_BITS-1:0] bri);
      logic [LEVEL_BITS:0]   lvl;
      logic [SCALE_BITS-1:0] prod;
      if (high) begin
         lvl = {1'b1, LEVEL_BITS'(0)};
      end else if (low) begin
         lvl = '0;
      end else begin
         lvl = {1'b0, quot};
      end
      prod = SCALE_BITS'(lvl) * SCALE_BITS'(bri);
      return prod[LEVEL_BITS +: LEVEL_OUT_BITS];
   endfunction

   // Configuration.
   logic [BRIGHT_BITS-1:0] bri_ff;

   // Flow control.
   logic advance;

   // Stage 1: offset hue, chroma product.
   logic                   p1_valid_ff;
   logic [HNUM_BITS-1:0]   p1_hnum_ff, p1_hnum_in;
   logic [CHROMA_BITS-1:0] p1_chroma_ff, p1_chroma_in;
   logic [VALUE_BITS-1:0]  p1_value_ff;

   // Hue wrap divider.
   logic                                hd_valid;
   logic [WRAP_BITS-1:0]                hd_wrap;
   logic [CHROMA_BITS+VALUE_BITS-1:0]   hd_side;
   logic [CHROMA_BITS-1:0]              hd_chroma;
   logic [VALUE_BITS-1:0]               hd_value;

   // Stage 5: sector decode.
   logic [SECTOR_BITS-1:0] sector;
   logic [WRAP_BITS-1:0]   sector_base;
   logic [SEC_BITS-1:0]    frac_units, rest_units;
   terms_type              terms;
   logic                   p5_valid_ff;
   logic [CHANNEL_COUNT-1:0][SEC_BITS-1:0] p5_units_ff, p5_units_in;
   logic [CHROMA_BITS-1:0] p5_chroma_ff;
   logic [VALUE_BITS-1:0]  p5_value_ff;

   // Stage 6: products.
   logic                   p6_valid_ff;
   logic [CHANNEL_COUNT-1:0][PROD_BITS-1:0] p6_prod_ff, p6_prod_in;
   logic [BASE_BITS-1:0]   p6_base_ff, p6_base_in;

   // Stage 7: clamp and quantizer numerator.
   logic [CHANNEL_COUNT-1:0][NUM_BITS-1:0]  chan_num;
   logic                   p7_valid_ff;
   logic [CHANNEL_COUNT-1:0][QNUM_BITS-1:0] p7_qnum_ff, p7_qnum_in;
   logic [CHANNEL_COUNT-1:0][1:0]           p7_clamp_ff, p7_clamp_in;

   // Quantizer dividers.
   logic [CHANNEL_COUNT-1:0]                 cd_valid;
   logic [CHANNEL_COUNT-1:0][LEVEL_BITS-1:0] cd_quot;
   logic [CHANNEL_COUNT-1:0][1:0]            cd_clamp;
   logic [CHANNEL_COUNT-1:0][FRAC_BITS-1:0]  cd_rem;

   // Output buffer.
   levels_type level_in;
   logic       rsp_valid_ff, skid_valid_ff;
   levels_type rsp_level_ff, rsp_level_in, skid_level_ff;
   logic       rsp_free, incoming;

   // Brightness register: write whenever enabled.
   always_ff @(posedge clock) begin
      if (reset) begin
         bri_ff <= BRIGHTNESS_RESET;
      end else if (csr_write_enable) begin
         bri_ff <= csr_write_data;
      end
   end

   // Advance the whole pipeline unless the skid entry is occupied.
   assign advance   = !skid_valid_ff;
   assign req_ready = advance;

   // Stage 1: shift hue to an unsigned code and add an offset that keeps
   // the remainder modulo a full circle equal to the signed hue's.
   assign p1_hnum_in   = HNUM_BITS'({~req_hue[HUE_BITS-1], req_hue[HUE_BITS-2:0]})
                       + HNUM_BITS'(HUE_OFFSET);
   assign p1_chroma_in = CHROMA_BITS'(req_saturation) * CHROMA_BITS'(req_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p5_valid_ff <= 1'b0;
         p6_valid_ff <= 1'b0;
         p7_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= req_valid;
         p5_valid_ff <= hd_valid;
         p6_valid_ff <= p5_valid_ff;
         p7_valid_ff <= p6_valid_ff;
      end
   end

   // Wrap hue into one circle.
   hsv_cdiv #(
      .DIVISOR   (CIRCLE),
      .NUM_BITS  (HNUM_BITS),
      .QUO_BITS  (HQUO_BITS),
      .REM_BITS  (WRAP_BITS),
      .SIDE_BITS (CHROMA_BITS + VALUE_BITS)
   ) u_hue_wrap (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    ('{advance: advance, valid: p1_valid_ff}),
      .in_num    (p1_hnum_ff),
      .in_side   ({p1_chroma_ff, p1_value_ff}),
      .out_valid (hd_valid),
      .out_quot  (),
      .out_rem   (hd_wrap),
      .out_side  (hd_side)
   );

   assign {hd_chroma, hd_value} = hd_side;

   // Stage 5: find the sector and the position within it, then pick for
   // each channel how many sector units of chroma to take away from v.
   always_comb begin
      sector      = '0;
      sector_base = '0;
      for (int k = 1; k < SECTOR_COUNT; k++) begin
         if (hd_wrap >= WRAP_BITS'(k * SECTOR)) begin
            sector      = SECTOR_BITS'(k);
            sector_base = WRAP_BITS'(k * SECTOR);
         end
      end
      frac_units = SEC_BITS'(hd_wrap - sector_base);
      rest_units = SEC_BITS'(SECTOR) - frac_units;
      terms      = sector_terms(sector);
      p5_units_in[0] = pick_units(terms.red,   frac_units, rest_units);
      p5_units_in[1] = pick_units(terms.green, frac_units, rest_units);
      p5_units_in[2] = pick_units(terms.blue,  frac_units, rest_units);
   end

   // Stage 6: channel = v*256*S - chroma*units, both over 65536*S.
   assign p6_base_in = BASE_BITS'(p5_value_ff) * BASE_BITS'(SECTOR * 256);

   // Stage 7: clamp flags and quantizer numerator floor(num * 2^L / 65536).
   always_comb begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
         p6_prod_in[i] = PROD_BITS'(p5_chroma_ff) * PROD_BITS'(p5_units_ff[i]);
         chan_num[i]   = NUM_BITS'(p6_base_ff) - NUM_BITS'(p6_prod_ff[i]);
         p7_clamp_in[i][1] = chan_num[i][NUM_BITS-1] || (chan_num[i] == '0);
         p7_clamp_in[i][0] = !chan_num[i][NUM_BITS-1]
                           && (chan_num[i] >= NUM_BITS'(FULL_NUM));
         p7_qnum_in[i] = QNUM_BITS'(chan_num[i] >> SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_hnum_ff   <= p1_hnum_in;
         p1_chroma_ff <= p1_chroma_in;
         p1_value_ff  <= req_value;
         p5_units_ff  <= p5_units_in;
         p5_chroma_ff <= hd_chroma;
         p5_value_ff  <= hd_value;
         p6_prod_ff   <= p6_prod_in;
         p6_base_ff   <= p6_base_in;
         p7_qnum_ff   <= p7_qnum_in;
         p7_clamp_ff  <= p7_clamp_in;
      end
   end

   // Quantize each channel: divide by the sector size.
   for (genvar g = 0; g < CHANNEL_COUNT; g++) begin : g_quant
      hsv_cdiv #(
         .DIVISOR   (SECTOR),
         .NUM_BITS  (QNUM_BITS),
         .QUO_BITS  (LEVEL_BITS),
         .REM_BITS  (FRAC_BITS),
         .SIDE_BITS (2)
      ) u_quant (
         .clock     (clock),
         .reset     (reset),
         .in_ctl    ('{advance: advance, valid: p7_valid_ff}),
         .in_num    (p7_qnum_ff[g]),
         .in_side   (p7_clamp_ff[g]),
         .out_valid (cd_valid[g]),
         .out_quot  (cd_quot[g]),
         .out_rem   (cd_rem[g]),
         .out_side  (cd_clamp[g])
      );
   end

   // Scale by brightness. Clamp bit 1 means at or below zero, bit 0 means
   // at or above full scale.
   always_comb begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
         level_in[i] = scale_level(cd_quot[i], cd_clamp[i][1], cd_clamp[i][0], bri_ff);
      end
   end

   // Output register plus skid register. All lanes move together, so the
   // red lane's valid stands for the item.
   assign rsp_free     = !rsp_valid_ff || rsp_ready;
   assign incoming     = advance && cd_valid[0];
   assign rsp_level_in = skid_valid_ff ? skid_level_ff : level_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff  <= skid_valid_ff || incoming;
         skid_valid_ff <= 1'b0;
      end else if (incoming) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         rsp_level_ff <= rsp_level_in;
      end else if (incoming) begin
         skid_level_ff <= level_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_level_ff[0];
   assign rsp_green = rsp_level_ff[1];
   assign rsp_blue  = rsp_level_ff[2];

endmodule

@@ hdl/hsv_cdiv.sv @@
// Three-stage pipelined division by a constant: reciprocal multiply,
// back-multiply, one correction step. Depends on hsv_pkg for pipe_ctl_type.
module hsv_cdiv
   import hsv_pkg::*;
#(
   parameter int unsigned DIVISOR   = 960,
   parameter int unsigned NUM_BITS  = 18,
   parameter int unsigned QUO_BITS  = 8,
   parameter int unsigned REM_BITS  = 10,
   parameter int unsigned SIDE_BITS = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pipe_ctl_type         in_ctl,
   input  logic [NUM_BITS-1:0]  in_num,
   input  logic [SIDE_BITS-1:0] in_side,
   output logic                 out_valid,
   output logic [QUO_BITS-1:0]  out_quot,
   output logic [REM_BITS-1:0]  out_rem,
   output logic [SIDE_BITS-1:0] out_side
);

   localparam longint unsigned RECIP = (64'd1 << NUM_BITS) / DIVISOR;
   localparam int unsigned RECIP_BITS = $clog2(RECIP + 1);
   localparam int unsigned PROD_BITS  = NUM_BITS + RECIP_BITS;

   logic                 a_valid_ff, b_valid_ff, c_valid_ff;
   logic [NUM_BITS-1:0]  a_num_ff, b_num_ff;
   logic [PROD_BITS-1:0] a_prod_ff, a_prod_in;
   logic [QUO_BITS-1:0]  b_quot_ff, b_quot_in, c_quot_ff, c_quot_in;
   logic [NUM_BITS-1:0]  b_back_ff, b_back_in, diff;
   logic [REM_BITS-1:0]  c_rem_ff, c_rem_in;
   logic [SIDE_BITS-1:0] a_side_ff, b_side_ff, c_side_ff;

   // Estimate is the true quotient or one less.
   assign a_prod_in = PROD_BITS'(in_num) * PROD_BITS'(RECIP);
   assign b_quot_in = QUO_BITS'(a_prod_ff >> NUM_BITS);
   assign b_back_in = NUM_BITS'(NUM_BITS'(b_quot_in) * NUM_BITS'(DIVISOR));
   assign diff      = b_num_ff - b_back_ff;

   always_comb begin
      if (diff >= NUM_BITS'(DIVISOR)) begin
         c_quot_in = b_quot_ff + QUO_BITS'(1);
         c_rem_in  = REM_BITS'(diff - NUM_BITS'(DIVISOR));
      end else begin
         c_quot_in = b_quot_ff;
         c_rem_in  = REM_BITS'(diff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (in_ctl.advance) begin
         a_valid_ff <= in_ctl.valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ctl.advance) begin
         a_num_ff  <= in_num;
         a_prod_ff <= a_prod_in;
         a_side_ff <= in_side;
         b_num_ff  <= a_num_ff;
         b_quot_ff <= b_quot_in;
         b_back_ff <= b_back_in;
         b_side_ff <= a_side_ff;
         c_quot_ff <= c_quot_in;
         c_rem_ff  <= c_rem_in;
         c_side_ff <= b_side_ff;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_quot  = c_quot_ff;
   assign out_rem   = c_rem_ff;
   assign out_side  = c_side_ff;

endmodule
